// File: rtl/epr_pkg.sv
// epr_pkg: shared constants, codes and types for the euler point rotation core
// holds the quarter-wave sine table (q1.15, whole degrees) used to build coefficients
// no dependencies
package epr_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int TRIG_WIDTH_DEF  = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_Z = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ORDER   = 2'd3;

  // rotation axis codes, also the index into the coefficient registers
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       skip;
    logic [1:0] axis;
  } epr_rot_ctl_t;

  localparam logic [15:0] SINE_TAB [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  function automatic logic [15:0] sine_q15(input logic [6:0] r);
    logic [15:0] v;
    v = 16'd0;
    if (r <= 7'd90) begin
      v = SINE_TAB[r];
    end
    return v;
  endfunction

endpackage

// File: rtl/epr_rot_stage.sv
// epr_rot_stage: one plane rotation of a 3d point, two register stages
// stage a holds the four products, stage b the rounded sums put back on their axes
// depends on epr_pkg (axis codes, control struct)
module epr_rot_stage #(
  parameter int IN_W       = epr_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_WIDTH = epr_pkg::TRIG_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [IN_W-1:0]        in_x,
  input  logic signed [IN_W-1:0]        in_y,
  input  logic signed [IN_W-1:0]        in_z,
  input  logic signed [TRIG_WIDTH-1:0]  sin_c,
  input  logic signed [TRIG_WIDTH-1:0]  cos_c,
  input  epr_pkg::epr_rot_ctl_t         ctl,
  output logic                          out_valid,
  output logic signed [IN_W:0]          out_x,
  output logic signed [IN_W:0]          out_y,
  output logic signed [IN_W:0]          out_z
);
  import epr_pkg::*;

  localparam int OUT_W = IN_W + 1;
  localparam int PW    = IN_W + TRIG_WIDTH;
  localparam int SW    = PW + 1;
  localparam int TF    = TRIG_WIDTH - 1;
  localparam logic signed [SW-1:0] HALF = SW'(1 << (TF - 1));

  logic signed [IN_W-1:0] u, v, w;

  logic signed [PW-1:0]   uc_r, vs_r, us_r, vc_r;
  logic signed [IN_W-1:0] u_r, v_r, w_r;
  epr_rot_ctl_t           ctl_r;
  logic                   valid_a_r;

  logic signed [SW-1:0]    sum_u, sum_v;
  logic signed [SW-1:0]    shf_u, shf_v;
  logic signed [OUT_W-1:0] nu, nv, nw;

  logic signed [OUT_W-1:0] x_r, y_r, z_r;
  logic                    valid_b_r;

  // pick the rotated pair and the untouched coordinate
  always_comb begin
    case (ctl.axis)
      AXIS_X: begin
        u = in_y; v = in_z; w = in_x;
      end
      AXIS_Y: begin
        u = in_x; v = in_z; w = in_y;
      end
      AXIS_Z: begin
        u = in_x; v = in_y; w = in_z;
      end
      default: begin
        u = in_x; v = in_y; w = in_z;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (en) begin
      valid_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uc_r  <= PW'(u) * PW'(cos_c);
      vs_r  <= PW'(v) * PW'(sin_c);
      us_r  <= PW'(u) * PW'(sin_c);
      vc_r  <= PW'(v) * PW'(cos_c);
      u_r   <= u;
      v_r   <= v;
      w_r   <= w;
      ctl_r <= ctl;
    end
  end

  // round half up: add half then floor shift
  always_comb begin
    sum_u = SW'(uc_r) - SW'(vs_r) + HALF;
    sum_v = SW'(us_r) + SW'(vc_r) + HALF;
    shf_u = sum_u >>> TF;
    shf_v = sum_v >>> TF;
    nw    = OUT_W'(w_r);
    if (ctl_r.skip) begin
      nu = OUT_W'(u_r);
      nv = OUT_W'(v_r);
    end else begin
      nu = OUT_W'(shf_u);
      nv = OUT_W'(shf_v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (en) begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (ctl_r.axis)
        AXIS_X: begin
          x_r <= nw; y_r <= nu; z_r <= nv;
        end
        AXIS_Y: begin
          x_r <= nu; y_r <= nw; z_r <= nv;
        end
        AXIS_Z: begin
          x_r <= nu; y_r <= nv; z_r <= nw;
        end
        default: begin
          x_r <= nu; y_r <= nv; z_r <= nw;
        end
      endcase
    end
  end

  assign out_valid = valid_b_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;

endmodule

// File: rtl/euler_point_rotation_core.sv
// euler_point_rotation_core: top level, streams 3d points through three plane rotations
// holds the angle coefficient registers, the rotation chain and the saturating output stage
// depends on epr_pkg and epr_rot_stage
//
// Rotates each point (px, py, pz) by three angles in whole degrees, Z then X then Y, or
// Y then X then Z when the order register is set, and clips the result to the coordinate range,
// flagging any clip on out_tuser. A point is taken every cycle unless the pipeline holds. The
// path has seven register stages (two per rotation, product registers then rounded sums,
// plus the saturation register). While a result waits with out_tready low the whole
// pipeline holds, and in_tready follows it. Sine and cosine are looked up from the write
// data on the configuration write itself; write the port only while no point is in flight.
module euler_point_rotation_core #(
  parameter int COORD_WIDTH = epr_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_WIDTH  = epr_pkg::TRIG_WIDTH_DEF,
  localparam int DATA_W     = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [epr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [epr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [DATA_W-1:0]                in_tdata,   // px, py, pz, zero pad
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [DATA_W-1:0]                out_tdata,  // rx, ry, rz, zero pad
  output logic [0:0]                       out_tuser   // saturated
);
  import epr_pkg::*;

  localparam int UP   = (TRIG_WIDTH >= 16) ? TRIG_WIDTH - 16 : 0;
  localparam int DN   = (TRIG_WIDTH < 16) ? 16 - TRIG_WIDTH : 0;
  localparam int VW   = 17 + UP;
  localparam int HALF = (1 << DN) >> 1;
  localparam int TOP  = (1 << (TRIG_WIDTH - 1)) - 1;
  localparam int W3   = COORD_WIDTH + 3;
  localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] C_MIN = ~C_MAX;

  function automatic logic signed [TRIG_WIDTH-1:0] coef(input logic [8:0] ang,
                                                        input logic       cos_sel);
    logic [9:0]                  a;
    logic [6:0]                  r;
    logic                        neg;
    logic [VW-1:0]               v;
    logic signed [TRIG_WIDTH-1:0] mag;
    a = {1'b0, ang};
    if (a >= 10'd360) a = a - 10'd360;
    if (cos_sel) begin
      a = a + 10'd90;
      if (a >= 10'd360) a = a - 10'd360;
    end
    if (a <= 10'd90) begin
      r = a[6:0]; neg = 1'b0;
    end else if (a <= 10'd180) begin
      r = 7'(10'd180 - a); neg = 1'b0;
    end else if (a <= 10'd270) begin
      r = 7'(a - 10'd180); neg = 1'b1;
    end else begin
      r = 7'(10'd360 - a); neg = 1'b1;
    end
    v = (VW'(sine_q15(r)) << UP) + VW'(HALF);
    v = v >> DN;
    if (v > VW'(TOP)) v = VW'(TOP);
    mag = TRIG_WIDTH'(v);
    return neg ? -mag : mag;
  endfunction

  function automatic logic is_zero_angle(input logic [8:0] ang);
    return (ang == 9'd0) || (ang == 9'd360);
  endfunction

  // coefficient registers, indexed by axis code
  logic signed [TRIG_WIDTH-1:0] sin_r [3];
  logic signed [TRIG_WIDTH-1:0] cos_r [3];
  logic [2:0]                   skip_r;
  logic                         mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        sin_r[i] <= '0;
        cos_r[i] <= TRIG_WIDTH'(TOP);
      end
      skip_r <= 3'b111;
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ANGLE_X: begin
          sin_r[AXIS_X]  <= coef(cfg_wdata, 1'b0);
          cos_r[AXIS_X]  <= coef(cfg_wdata, 1'b1);
          skip_r[AXIS_X] <= is_zero_angle(cfg_wdata);
        end
        REG_ANGLE_Y: begin
          sin_r[AXIS_Y]  <= coef(cfg_wdata, 1'b0);
          cos_r[AXIS_Y]  <= coef(cfg_wdata, 1'b1);
          skip_r[AXIS_Y] <= is_zero_angle(cfg_wdata);
        end
        REG_ANGLE_Z: begin
          sin_r[AXIS_Z]  <= coef(cfg_wdata, 1'b0);
          cos_r[AXIS_Z]  <= coef(cfg_wdata, 1'b1);
          skip_r[AXIS_Z] <= is_zero_angle(cfg_wdata);
        end
        REG_ORDER: begin
          mode_r <= cfg_wdata[0];
        end
        default: begin
          mode_r <= mode_r;
        end
      endcase
    end
  end

  // pipeline advances whenever the output register is free or being drained
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic signed [COORD_WIDTH-1:0] px, py, pz;
  assign px = in_tdata[COORD_WIDTH-1:0];
  assign py = in_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign pz = in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

  logic [1:0]   axis1, axis3;
  epr_rot_ctl_t ctl1, ctl2, ctl3;
  assign axis1 = mode_r ? AXIS_Y : AXIS_Z;
  assign axis3 = mode_r ? AXIS_Z : AXIS_Y;
  assign ctl1  = '{skip: skip_r[axis1], axis: axis1};
  assign ctl2  = '{skip: skip_r[AXIS_X], axis: AXIS_X};
  assign ctl3  = '{skip: skip_r[axis3], axis: axis3};

  logic                          v1, v2, v3;
  logic signed [COORD_WIDTH:0]   x1, y1, z1;
  logic signed [COORD_WIDTH+1:0] x2, y2, z2;
  logic signed [W3-1:0]          x3, y3, z3;

  epr_rot_stage #(.IN_W(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_rot1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .in_x(px), .in_y(py), .in_z(pz),
    .sin_c(sin_r[axis1]), .cos_c(cos_r[axis1]), .ctl(ctl1),
    .out_valid(v1), .out_x(x1), .out_y(y1), .out_z(z1)
  );

  epr_rot_stage #(.IN_W(COORD_WIDTH + 1), .TRIG_WIDTH(TRIG_WIDTH)) u_rot2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v1),
    .in_x(x1), .in_y(y1), .in_z(z1),
    .sin_c(sin_r[AXIS_X]), .cos_c(cos_r[AXIS_X]), .ctl(ctl2),
    .out_valid(v2), .out_x(x2), .out_y(y2), .out_z(z2)
  );

  epr_rot_stage #(.IN_W(COORD_WIDTH + 2), .TRIG_WIDTH(TRIG_WIDTH)) u_rot3 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2),
    .in_x(x2), .in_y(y2), .in_z(z2),
    .sin_c(sin_r[axis3]), .cos_c(cos_r[axis3]), .ctl(ctl3),
    .out_valid(v3), .out_x(x3), .out_y(y3), .out_z(z3)
  );

  // in range when all bits above the coordinate's sign bit copy it
  function automatic logic fits(input logic signed [W3-1:0] val);
    return (val[W3-1:COORD_WIDTH-1] == '0) || (val[W3-1:COORD_WIDTH-1] == '1);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] clip(input logic signed [W3-1:0] val);
    logic signed [COORD_WIDTH-1:0] res;
    if (fits(val)) res = COORD_WIDTH'(val);
    else if (val[W3-1]) res = C_MIN;
    else res = C_MAX;
    return res;
  endfunction

  logic signed [COORD_WIDTH-1:0] rx_r, ry_r, rz_r;
  logic                          sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r  <= clip(x3);
      ry_r  <= clip(y3);
      rz_r  <= clip(z3);
      sat_r <= !(fits(x3) && fits(y3) && fits(z3));
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = DATA_W'({rz_r, ry_r, rx_r});
  assign out_tuser[0] = sat_r;

  // a clip flag implies some coordinate sits on a range limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r |->
      (rx_r == C_MAX) || (rx_r == C_MIN) || (ry_r == C_MAX) ||
      (ry_r == C_MIN) || (rz_r == C_MAX) || (rz_r == C_MIN))
    else $error("saturation flag without a clipped coordinate");

  // writing a full turn or zero to the z angle must turn that rotation off
  a_zero_angle_skip: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en && (cfg_index == REG_ANGLE_Z) &&
    ((cfg_wdata == 9'd0) || (cfg_wdata == 9'd360)) |=> skip_r[AXIS_Z])
    else $error("zero angle did not mark rotation as skipped");

  // coefficients never reach the most negative code
  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cos_r[AXIS_X] != {1'b1, {(TRIG_WIDTH-1){1'b0}}}) &&
    (sin_r[AXIS_X] != {1'b1, {(TRIG_WIDTH-1){1'b0}}}) &&
    (cos_r[AXIS_Y] != {1'b1, {(TRIG_WIDTH-1){1'b0}}}) &&
    (sin_r[AXIS_Y] != {1'b1, {(TRIG_WIDTH-1){1'b0}}}) &&
    (cos_r[AXIS_Z] != {1'b1, {(TRIG_WIDTH-1){1'b0}}}) &&
    (sin_r[AXIS_Z] != {1'b1, {(TRIG_WIDTH-1){1'b0}}}))
    else $error("trig coefficient out of range");

  // a stall freezes each rotation's output valid bit and the output valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({v1, v2, v3, out_valid_r}))
    else $error("pipeline moved during a stall");

endmodule

// File: test/euler_point_rotation_core_tb.sv
// euler_point_rotation_core_tb: self-checking bench for the euler point rotation core
// predicts each rotated point from the configured angles and order, checks every result
// depends on epr_pkg and euler_point_rotation_core
`timescale 1ns / 1ps

module euler_point_rotation_core_tb;

  localparam int     CW          = epr_pkg::COORD_WIDTH_DEF;
  localparam int     DATA_W      = ((3 * CW + 7) / 8) * 8;
  localparam int     TRIG_FRAC   = epr_pkg::TRIG_WIDTH_DEF - 1;
  localparam longint COEF_TOP    = (longint'(1) << TRIG_FRAC) - 1;
  localparam longint COORD_MAX   = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN   = -(longint'(1) << (CW - 1));
  localparam int     QUIET_LIMIT = 2000;
  localparam logic   ORDER_ZXY   = 1'b0;
  localparam logic   ORDER_YXZ   = 1'b1;
  localparam int     KEY_ANGLES [8] = '{0, 45, 90, 180, 270, 359, 360, 511};

  localparam logic [CW-1:0] P_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] P_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [CW-1:0] rx;
    logic [CW-1:0] ry;
    logic [CW-1:0] rz;
    logic          sat;
  } rotated_t;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            cfg_wr_en  = 1'b0;
  logic [epr_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [epr_pkg::CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [DATA_W-1:0]               in_tdata   = '0;  // px, py, pz from bit 0 up
  logic                            out_tready = 1'b1;
  logic                            out_tvalid;
  logic [DATA_W-1:0]               out_tdata;        // rx, ry, rz from bit 0 up
  logic [0:0]                      out_tuser;        // saturated

  // bench copy of the angle registers
  logic [8:0] deg_x     = '0;
  logic [8:0] deg_y     = '0;
  logic [8:0] deg_z     = '0;
  logic       order_yxz = ORDER_ZXY;

  rotated_t rotated_q [$];
  rotated_t seen_pt;
  rotated_t want_pt;
  bit       src_gaps    = 1'b0;
  bit       sink_stalls = 1'b0;
  int       mismatches  = 0;
  int       quiet_cycles = 0;
  int       hold_left   = 0;

  euler_point_rotation_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // signed coefficient from the quarter-wave table, unit value held just below one
  function automatic longint sine_coef(input int unsigned deg);
    int unsigned a;
    int unsigned r;
    bit          neg;
    longint      v;
    a   = deg % 360;
    neg = 1'b0;
    if (a <= 90) begin
      r = a;
    end else if (a <= 180) begin
      r = 180 - a;
    end else if (a <= 270) begin
      r = a - 180;
      neg = 1'b1;
    end else begin
      r = 360 - a;
      neg = 1'b1;
    end
    v = longint'(epr_pkg::SINE_TAB[r]);
    if (v > COEF_TOP) v = COEF_TOP;
    return neg ? -v : v;
  endfunction

  function automatic void plane_turn(inout longint u, inout longint v, input logic [8:0] deg);
    longint s;
    longint c;
    longint nu;
    if (deg % 360 == 0) return;
    s  = sine_coef(deg);
    c  = sine_coef(deg % 360 + 90);
    // round half up, arithmetic shift floors
    nu = (u * c - v * s + (longint'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    v  = (u * s + v * c + (longint'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    u  = nu;
  endfunction

  function automatic logic [CW-1:0] clip_coord(input longint v, inout logic sat);
    if (v > COORD_MAX) begin
      v = COORD_MAX;
      sat = 1'b1;
    end else if (v < COORD_MIN) begin
      v = COORD_MIN;
      sat = 1'b1;
    end
    return v[CW-1:0];
  endfunction

  function automatic rotated_t rotate_point(input logic [CW-1:0] px, py, pz);
    longint   x;
    longint   y;
    longint   z;
    logic     sat;
    rotated_t r;
    x = longint'(signed'(px));
    y = longint'(signed'(py));
    z = longint'(signed'(pz));
    if (order_yxz == ORDER_ZXY) begin
      plane_turn(x, y, deg_z);
      plane_turn(y, z, deg_x);
      plane_turn(x, z, deg_y);
    end else begin
      plane_turn(x, z, deg_y);
      plane_turn(y, z, deg_x);
      plane_turn(x, y, deg_z);
    end
    // intermediates stay wide, only the final point is clipped
    sat   = 1'b0;
    r.rx  = clip_coord(x, sat);
    r.ry  = clip_coord(y, sat);
    r.rz  = clip_coord(z, sat);
    r.sat = sat;
    return r;
  endfunction

  function automatic logic [8:0] pick_angle();
    case ($urandom_range(0, 3))
      0:       return 9'(KEY_ANGLES[$urandom_range(0, 7)]);
      1:       return 9'($urandom_range(360, 511));
      default: return 9'($urandom_range(0, 359));
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_coord();
    int s;
    case ($urandom_range(0, 5))
      0: return P_MAX;
      1: return P_MIN;
      2: begin
        s = int'($urandom_range(0, 1023)) - 512;
        return s[CW-1:0];
      end
      default: return CW'($urandom());
    endcase
  endfunction

  // one point request; valid is left high so back-to-back requests need no gap
  task automatic send_point(input logic [CW-1:0] px, py, pz);
    int gap;
    gap = 0;
    if (src_gaps && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pz, py, px};
    do @(posedge clk); while (!in_tready);
    rotated_q.push_back(rotate_point(px, py, pz));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    // pipeline is seven deep, leave room for any stray result
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [epr_pkg::CFG_INDEX_W-1:0] idx, input logic [8:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      epr_pkg::REG_ANGLE_X: deg_x = val;
      epr_pkg::REG_ANGLE_Y: deg_y = val;
      epr_pkg::REG_ANGLE_Z: deg_z = val;
      epr_pkg::REG_ORDER:   order_yxz = val[0];
      default: ;
    endcase
  endtask

  task automatic set_angles(input logic [8:0] ax, ay, az, input logic ord);
    wait_idle();
    write_reg(epr_pkg::REG_ANGLE_X, ax);
    write_reg(epr_pkg::REG_ANGLE_Y, ay);
    write_reg(epr_pkg::REG_ANGLE_Z, az);
    write_reg(epr_pkg::REG_ORDER, {8'd0, ord});
  endtask

  // reset angles are zero, so points must come back untouched
  task automatic test_identity();
    send_point(P_MAX, P_MIN, 24'h000000);
    send_point(P_MIN, P_MAX, 24'hFFFFFF);
    send_point(24'h000001, 24'h555555, 24'hAAAAAA);
    send_point(24'h000000, 24'h000000, 24'h000000);
  endtask

  // quarter turns, where sine or cosine is a full unit
  task automatic test_unit_coefficients();
    set_angles(9'd90, 9'd180, 9'd270, ORDER_ZXY);
    send_point(P_MAX, P_MIN, 24'h123456);
    send_point(24'h000100, 24'hFFFF00, P_MAX);
    set_angles(9'd90, 9'd180, 9'd270, ORDER_YXZ);
    send_point(P_MAX, P_MIN, 24'h123456);
    send_point(24'h000100, 24'hFFFF00, P_MAX);
  endtask

  task automatic test_saturation();
    set_angles(9'd0, 9'd0, 9'd45, ORDER_ZXY);
    send_point(P_MAX, P_MAX, 24'h000000);
    send_point(P_MIN, P_MIN, P_MIN);
    send_point(P_MAX, P_MIN, P_MAX);
    set_angles(9'd45, 9'd315, 9'd45, ORDER_YXZ);
    send_point(P_MAX, P_MAX, P_MAX);
    send_point(P_MIN, P_MAX, P_MIN);
  endtask

  // 360 must be skipped, 450 acts as 90, 511 as 151
  task automatic test_angle_wrap();
    set_angles(9'd360, 9'd511, 9'd450, ORDER_ZXY);
    send_point(24'h012345, 24'hFEDCBA, P_MAX);
    send_point(P_MIN, 24'h000001, P_MAX);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        set_angles(9'd0, 9'd359, 9'd511, ORDER_ZXY);
      end else if (p == 1) begin
        set_angles(9'd359, 9'd360, 9'd0, ORDER_YXZ);
      end else begin
        set_angles(pick_angle(), pick_angle(), pick_angle(), 1'($urandom_range(0, 1)));
      end
      src_gaps    = (p != 7) && (p % 3 != 2);
      sink_stalls = (p != 7) && (p % 4 != 3);
      repeat (55) send_point(pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  // result sink back-pressure in random bursts while sink_stalls is set
  always @(posedge clk) begin
    if (!sink_stalls) begin
      out_tready <= 1'b1;
      hold_left  <= 0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if ($urandom_range(0, 6) == 0) begin
      out_tready <= 1'b0;
      hold_left  <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_pt.rx  = out_tdata[CW-1:0];
      seen_pt.ry  = out_tdata[2*CW-1:CW];
      seen_pt.rz  = out_tdata[3*CW-1:2*CW];
      seen_pt.sat = out_tuser[0];
      if (rotated_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result rx=%h ry=%h rz=%h sat=%b", seen_pt.rx, seen_pt.ry,
                   seen_pt.rz, seen_pt.sat);
      end else begin
        want_pt = rotated_q.pop_front();
        if (seen_pt.rx !== want_pt.rx || seen_pt.ry !== want_pt.ry ||
            seen_pt.rz !== want_pt.rz || seen_pt.sat !== want_pt.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rx=%h ry=%h rz=%h sat=%b, got rx=%h ry=%h rz=%h sat=%b",
                     want_pt.rx, want_pt.ry, want_pt.rz, want_pt.sat,
                     seen_pt.rx, seen_pt.ry, seen_pt.rz, seen_pt.sat);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    test_identity();
    test_unit_coefficients();
    test_saturation();
    test_angle_wrap();
    test_random_phases();
    wait_idle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
